[rtl/iee_pkg.sv]
// iee_pkg: shared types and codes for the infix expression evaluator
// used by every module of the block, no dependencies
package iee_pkg;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_INVALID   = 3'd1;
  localparam logic [2:0] ERR_MALFORMED = 3'd2;
  localparam logic [2:0] ERR_DIVZERO   = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // arithmetic unit operations
  typedef enum logic [1:0] {
    AU_MUL = 2'd0,
    AU_DIV = 2'd1,
    AU_MAC = 2'd2
  } au_op_t;

  typedef struct packed {
    logic   start;
    au_op_t op;
  } au_req_t;

endpackage

[rtl/iee_arith.sv]
// iee_arith: bit-serial multiplier, restoring divider and times-ten-plus-digit unit
// depends on iee_pkg
module iee_arith #(
  parameter int W = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  iee_pkg::au_req_t req,
  input  logic [W-1:0]    a,
  input  logic [W-1:0]    b,
  output logic            busy,
  output logic            done,
  output logic [W-1:0]    res
);
  import iee_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  acc_r, acc_nxt;   // product or remainder
  logic [W-1:0]  q_r, q_nxt;       // multiplier bits / quotient
  logic [W-1:0]  m_r, m_nxt;       // multiplicand / divisor
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  au_op_t        op_r, op_nxt;
  logic [W:0]    trial;

  always_comb begin
    acc_nxt = acc_r; q_nxt = q_r; m_nxt = m_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; op_nxt = op_r; done_nxt = 1'b0;
    trial = '0;
    if (!busy_r && req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      cnt_nxt  = CW'(W);
      m_nxt    = b;
      q_nxt    = a;
      acc_nxt  = '0;
      if (req.op == AU_MAC) begin
        // a times ten by shift-add: (a<<3)+(a<<1)+b, one step each
        q_nxt   = a;
        acc_nxt = b;
        cnt_nxt = CW'(2);
      end
    end else if (busy_r) begin
      unique case (op_r)
        AU_MUL: begin
          if (q_r[0]) acc_nxt = acc_r + m_r;
          m_nxt = m_r << 1;
          q_nxt = q_r >> 1;
        end
        AU_DIV: begin
          trial = {acc_r, q_r[W-1]} - {1'b0, m_r};
          if (!trial[W]) begin
            acc_nxt = trial[W-1:0];
            q_nxt   = {q_r[W-2:0], 1'b1};
          end else begin
            acc_nxt = {acc_r[W-2:0], q_r[W-1]};
            q_nxt   = {q_r[W-2:0], 1'b0};
          end
        end
        AU_MAC: begin
          acc_nxt = acc_r + (cnt_r == CW'(2) ? (q_r << 3) : (q_r << 1));
        end
        default: ;
      endcase
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt; q_r <= q_nxt; m_r <= m_nxt; cnt_r <= cnt_nxt; op_r <= op_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign res  = (op_r == AU_DIV) ? q_r : acc_r;
endmodule

[rtl/infix_expression_evaluator_unit.sv]
// infix_expression_evaluator_unit: top level, character parser and evaluation sequencer
// depends on iee_pkg and iee_arith
// An item is one character or an end command. Spaces, operators and invalid
// characters are handled in the idle state; a digit is issued to the shared serial
// unit for the times-ten add (two shift-add steps) and then written back. A digit
// that starts a new literal first commits the previous one, also waiting for the
// serial unit when that finishes a multiply or divide. An end command commits the
// last value the same way, unless an error is already known, and then loads the
// result. The result item sits in an output register, so characters of the next
// expression are taken while it waits; only a second end command stalls until the
// first result drains.
module infix_expression_evaluator_unit #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_character,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_value,
  output logic [2:0]  out_error_code
);
  import iee_pkg::*;

  localparam int W = VALUE_WIDTH;
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DIGIT  = 6'b000010,  // wait for times-ten add
    S_COMMIT = 6'b000100,  // commit held literal, then digit or end
    S_MWAIT  = 6'b001000,  // wait for mul or div
    S_POST   = 6'b010000,  // finish commit after mul/div
    S_END    = 6'b100000   // load result register once it is free
  } state_t;

  state_t state_r, state_nxt;

  logic [W-1:0] sum_r, sum_nxt, term_r, term_nxt, mag_r, mag_nxt, held_r, held_nxt;
  logic         neg_r, neg_nxt, lovf_r, lovf_nxt, held_ovf_r, held_ovf_nxt;
  logic         term_held_r, term_held_nxt, dsyn_r, dsyn_nxt, dseen_r, dseen_nxt;
  logic         inv_r, inv_nxt, malf_r, malf_nxt, aovf_r, aovf_nxt;
  logic [1:0]   phase_r, phase_nxt, pmul_r, pmul_nxt, held_op_r, held_op_nxt;
  logic         padd_r, padd_nxt;
  logic [2:0]   sticky_r, sticky_nxt;
  logic [3:0]   digit_r, digit_nxt;
  logic         qneg_r, qneg_nxt, end_r, end_nxt;
  logic [1:0]   cop_r, cop_nxt;   // operator closing the value being committed
  logic [63:0]  oval_r, oval_nxt;
  logic [2:0]   oerr_r, oerr_nxt;
  logic         ov_r, ov_nxt;

  au_req_t      au_req;
  logic [W-1:0] au_a, au_b, au_res;
  logic         au_busy, au_done;

  iee_arith #(.W(W)) u_arith (
    .clk(clk), .rst_n(rst_n), .req(au_req), .a(au_a), .b(au_b),
    .busy(au_busy), .done(au_done), .res(au_res)
  );

  localparam logic [1:0] PH_EXPECT = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;

  logic         acc;
  logic         is_digit, is_op;
  logic [1:0]   ch_op;
  logic [W-1:0] fin_val, cv;
  logic         fin_ovf, cvo;
  logic [W-1:0] lim;
  logic [W-1:0] tneg, vneg_abs;

  assign acc      = in_valid && in_ready;
  assign is_digit = (in_character >= CH_ZERO) && (in_character <= CH_NINE);
  assign is_op    = (in_character == CH_PLUS) || (in_character == CH_MINUS) ||
                    (in_character == CH_STAR) || (in_character == CH_SLASH);
  always_comb begin
    case (in_character)
      CH_MINUS: ch_op = OP_SUB;
      CH_STAR:  ch_op = OP_MUL;
      CH_SLASH: ch_op = OP_DIV;
      default:  ch_op = OP_ADD;
    endcase
  end

  assign fin_ovf = lovf_r || (neg_r ? (mag_r > VMIN) : (mag_r > VMAX));
  assign fin_val = neg_r ? (~mag_r + W'(1)) : mag_r;

  // literal*10+d <= VMIN  <=>  mag <= (VMIN-d)/10, one constant per digit
  always_comb begin
    case (digit_r)
      4'd0:    lim = (VMIN - W'(0)) / W'(10);
      4'd1:    lim = (VMIN - W'(1)) / W'(10);
      4'd2:    lim = (VMIN - W'(2)) / W'(10);
      4'd3:    lim = (VMIN - W'(3)) / W'(10);
      4'd4:    lim = (VMIN - W'(4)) / W'(10);
      4'd5:    lim = (VMIN - W'(5)) / W'(10);
      4'd6:    lim = (VMIN - W'(6)) / W'(10);
      4'd7:    lim = (VMIN - W'(7)) / W'(10);
      4'd8:    lim = (VMIN - W'(8)) / W'(10);
      4'd9:    lim = (VMIN - W'(9)) / W'(10);
      default: lim = '0;
    endcase
  end

  assign tneg     = term_r[W-1] ? (~term_r + W'(1)) : term_r;
  assign vneg_abs = cv[W-1] ? (~cv + W'(1)) : cv;

  always_comb begin
    state_nxt = state_r;
    sum_nxt = sum_r; term_nxt = term_r; mag_nxt = mag_r; held_nxt = held_r;
    neg_nxt = neg_r; lovf_nxt = lovf_r; held_ovf_nxt = held_ovf_r;
    term_held_nxt = term_held_r; dsyn_nxt = dsyn_r; dseen_nxt = dseen_r;
    inv_nxt = inv_r; malf_nxt = malf_r; aovf_nxt = aovf_r;
    phase_nxt = phase_r; pmul_nxt = pmul_r; held_op_nxt = held_op_r;
    padd_nxt = padd_r; sticky_nxt = sticky_r; digit_nxt = digit_r;
    qneg_nxt = qneg_r; end_nxt = end_r; cop_nxt = cop_r;
    oval_nxt = oval_r; oerr_nxt = oerr_r;
    ov_nxt = ov_r && !out_ready;
    au_req = '{start: 1'b0, op: AU_MUL};
    au_a = '0; au_b = '0;
    cv = held_r; cvo = held_ovf_r;
    in_ready = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        digit_nxt = in_character[3:0];
        if (acc) begin
          if (in_command) begin
            end_nxt = 1'b1;
            if (inv_r) begin
              sticky_nxt = ERR_INVALID; state_nxt = S_END;
            end else if (malf_r || !dseen_r) begin
              sticky_nxt = ERR_MALFORMED; state_nxt = S_END;
            end else begin
              if (phase_r == PH_DIGITS) begin
                held_nxt = fin_val; held_ovf_nxt = fin_ovf;
              end
              cop_nxt = OP_ADD;
              state_nxt = S_COMMIT;
            end
          end else if (in_character == CH_SPACE) begin
          end else if (is_digit) begin
            if (malf_r) begin
            end else if (dsyn_r) begin
              malf_nxt = 1'b1;
            end else if (phase_r != PH_DIGITS) begin
              end_nxt = 1'b0;
              cop_nxt = held_op_r;
              mag_nxt = '0; lovf_nxt = 1'b0;
              phase_nxt = PH_DIGITS;
              dseen_nxt = 1'b1;
              state_nxt = dseen_r ? S_COMMIT : S_DIGIT;
            end else begin
              state_nxt = S_DIGIT;
            end
          end else if (is_op) begin
            if (malf_r || dsyn_r) begin
            end else if (phase_r == PH_EXPECT) begin
              if (ch_op == OP_SUB) begin
                phase_nxt = PH_SIGN; neg_nxt = 1'b1;
              end else if (ch_op != OP_ADD) dsyn_nxt = 1'b1;
            end else if (phase_r == PH_SIGN) begin
              dsyn_nxt = 1'b1;
            end else begin
              held_nxt = fin_val; held_ovf_nxt = fin_ovf; held_op_nxt = ch_op;
              phase_nxt = PH_EXPECT; neg_nxt = 1'b0;
              mag_nxt = '0; lovf_nxt = 1'b0;
            end
          end else begin
            inv_nxt = 1'b1;
          end
        end
      end

      S_DIGIT: begin
        // overflow check against the bound, else start mag*10+d
        if (!au_busy && !au_done) begin
          if (lovf_r || mag_r > lim) begin
            lovf_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            au_req = '{start: 1'b1, op: AU_MAC};
            au_a = mag_r; au_b = W'(digit_r);
          end
        end else if (au_done) begin
          mag_nxt = au_res;
          state_nxt = S_IDLE;
        end
      end

      S_COMMIT: begin
        state_nxt = end_r ? S_END : S_DIGIT;
        if (sticky_r == ERR_NONE) begin
          if (term_held_r) begin
            if (cvo) begin
              sticky_nxt = ERR_OVERFLOW;
            end else if (pmul_r == 2'd1) begin
              au_req = '{start: 1'b1, op: AU_MUL};
              au_a = term_r; au_b = cv;
              state_nxt = S_MWAIT;
            end else if (cv == '0) begin
              sticky_nxt = ERR_DIVZERO;
            end else if (term_r == VMIN && cv == '1) begin
              sticky_nxt = ERR_OVERFLOW;
            end else begin
              au_req = '{start: 1'b1, op: AU_DIV};
              au_a = tneg; au_b = vneg_abs;
              qneg_nxt = term_r[W-1] ^ cv[W-1];
              state_nxt = S_MWAIT;
            end
          end else if (cop_r[1]) begin
            if (cvo) sticky_nxt = ERR_OVERFLOW;
            else begin
              term_nxt = cv; term_held_nxt = 1'b1;
              pmul_nxt = (cop_r == OP_MUL) ? 2'd1 : 2'd2;
            end
          end else begin
            if (cvo) aovf_nxt = 1'b1;
            sum_nxt = padd_r ? (sum_r - cv) : (sum_r + cv);
            padd_nxt = cop_r[0];
            term_held_nxt = 1'b0; pmul_nxt = 2'd0;
          end
        end
      end

      S_MWAIT: begin
        if (au_done) begin
          if (pmul_r == 2'd1) term_nxt = au_res;
          else term_nxt = qneg_r ? (~au_res + W'(1)) : au_res;
          state_nxt = S_POST;
        end
      end

      S_POST: begin
        state_nxt = end_r ? S_END : S_DIGIT;
        if (cop_r[1]) begin
          term_held_nxt = 1'b1;
          pmul_nxt = (cop_r == OP_MUL) ? 2'd1 : 2'd2;
        end else begin
          sum_nxt = padd_r ? (sum_r - term_r) : (sum_r + term_r);
          padd_nxt = cop_r[0];
          term_held_nxt = 1'b0; pmul_nxt = 2'd0;
        end
      end

      S_END: begin
        // value is zero whenever an error is reported
        if (!ov_r || out_ready) begin
          oval_nxt = '0;
          if (sticky_r != ERR_NONE) oerr_nxt = sticky_r;
          else if (aovf_r) oerr_nxt = ERR_OVERFLOW;
          else begin
            oerr_nxt = ERR_NONE;
            oval_nxt = 64'($signed(sum_r));
          end
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
          sum_nxt = '0; term_nxt = '0; mag_nxt = '0; held_nxt = '0;
          neg_nxt = 1'b0; lovf_nxt = 1'b0; held_ovf_nxt = 1'b0;
          term_held_nxt = 1'b0; dsyn_nxt = 1'b0; dseen_nxt = 1'b0;
          inv_nxt = 1'b0; malf_nxt = 1'b0; aovf_nxt = 1'b0;
          phase_nxt = PH_EXPECT; pmul_nxt = 2'd0; held_op_nxt = OP_ADD;
          padd_nxt = 1'b0; sticky_nxt = ERR_NONE; end_nxt = 1'b0;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sum_r <= '0; term_r <= '0; mag_r <= '0; held_r <= '0;
      neg_r <= 1'b0; lovf_r <= 1'b0; held_ovf_r <= 1'b0;
      term_held_r <= 1'b0; dsyn_r <= 1'b0; dseen_r <= 1'b0;
      inv_r <= 1'b0; malf_r <= 1'b0; aovf_r <= 1'b0;
      phase_r <= PH_EXPECT; pmul_r <= 2'd0; held_op_r <= OP_ADD;
      padd_r <= 1'b0; sticky_r <= ERR_NONE; end_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r <= sum_nxt; term_r <= term_nxt; mag_r <= mag_nxt; held_r <= held_nxt;
      neg_r <= neg_nxt; lovf_r <= lovf_nxt; held_ovf_r <= held_ovf_nxt;
      term_held_r <= term_held_nxt; dsyn_r <= dsyn_nxt; dseen_r <= dseen_nxt;
      inv_r <= inv_nxt; malf_r <= malf_nxt; aovf_r <= aovf_nxt;
      phase_r <= phase_nxt; pmul_r <= pmul_nxt; held_op_r <= held_op_nxt;
      padd_r <= padd_nxt; sticky_r <= sticky_nxt; end_r <= end_nxt;
      ov_r <= ov_nxt;
    end
    digit_r <= digit_nxt; qneg_r <= qneg_nxt; cop_r <= cop_nxt;
    oval_r <= oval_nxt; oerr_r <= oerr_nxt;
  end

  assign out_valid        = ov_r;
  assign out_result_value = oval_r;
  assign out_error_code   = oerr_r;
endmodule

[tb/infix_expression_evaluator_unit_test.sv]
// testbench for infix_expression_evaluator_unit: character streams checked against a
// built-in evaluator model; depends on iee_pkg and the rtl of the block
module infix_expression_evaluator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import iee_pkg::*;

  localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
  localparam logic [1:0] PH_EXPECT = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PM_NONE = 2'd0;
  localparam logic [1:0] PM_MUL  = 2'd1;
  localparam logic [1:0] PM_DIV  = 2'd2;
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = 1'b0;
  logic [7:0] in_character = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [63:0] out_result_value;
  logic [2:0] out_error_code;

  typedef struct {
    logic [63:0] value;
    logic [2:0]  code;
  } eval_result_t;

  eval_result_t pending_results[$];
  int mismatches = 0;
  int send_idle = 0;
  int recv_idle = 0;

  // evaluator model state
  logic [63:0] sum_acc, term_acc, lit_mag, held_val;
  logic lit_neg, lit_ovf, term_on, defer_err, had_digit, held_ovf, bad_char, broken, add_ovf;
  logic [1:0] phase, mul_pend, held_op;
  logic add_pend;
  logic [2:0] chain_err;

  infix_expression_evaluator_unit DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void clear_eval();
    sum_acc = '0; term_acc = '0; lit_mag = '0; held_val = '0;
    lit_neg = 0; lit_ovf = 0; term_on = 0; defer_err = 0; had_digit = 0;
    held_ovf = 0; bad_char = 0; broken = 0; add_ovf = 0;
    phase = PH_EXPECT; mul_pend = PM_NONE; held_op = OP_ADD; add_pend = 0;
    chain_err = ERR_NONE;
  endfunction

  function automatic void close_literal(output logic [63:0] v, output logic o);
    o = lit_ovf || (lit_neg ? (lit_mag > MOST_NEG) : (lit_mag > MOST_NEG - 64'd1));
    v = lit_neg ? -lit_mag : lit_mag;
  endfunction

  function automatic logic [63:0] trunc_div(logic [63:0] a, logic [63:0] b);
    logic [63:0] ma, mb, q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q = ma / mb;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic void fold_operand(logic [63:0] v, logic o, logic [1:0] op);
    logic is_mult;
    logic [63:0] t;
    is_mult = (op == OP_MUL) || (op == OP_DIV);
    if (chain_err != ERR_NONE) return;
    if (term_on) begin
      if (o) begin chain_err = ERR_OVERFLOW; return; end
      if (mul_pend == PM_MUL) begin
        term_acc = term_acc * v;
      end else begin
        if (v == 0) begin chain_err = ERR_DIVZERO; return; end
        if (term_acc == MOST_NEG && v == '1) begin chain_err = ERR_OVERFLOW; return; end
        term_acc = trunc_div(term_acc, v);
      end
    end else if (is_mult) begin
      if (o) begin chain_err = ERR_OVERFLOW; return; end
      term_acc = v;
    end
    if (is_mult) begin
      term_on = 1;
      mul_pend = (op == OP_MUL) ? PM_MUL : PM_DIV;
      return;
    end
    if (term_on) begin
      t = term_acc;
    end else begin
      if (o) add_ovf = 1;
      t = v;
    end
    sum_acc = add_pend ? sum_acc - t : sum_acc + t;
    add_pend = (op == OP_SUB);
    term_on = 0;
    mul_pend = PM_NONE;
  endfunction

  function automatic void eval_char(logic [7:0] c);
    logic [1:0] op;
    logic [63:0] d;
    if (c == CH_SPACE) return;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = 64'(c - CH_ZERO);
      if (broken) return;
      if (defer_err) begin broken = 1; return; end
      if (phase != PH_DIGITS) begin
        if (had_digit) fold_operand(held_val, held_ovf, held_op);
        lit_mag = '0; lit_ovf = 0; phase = PH_DIGITS; had_digit = 1;
      end
      if (lit_ovf || lit_mag > (MOST_NEG - d) / 64'd10) lit_ovf = 1;
      else lit_mag = lit_mag * 64'd10 + d;
      return;
    end
    case (c)
      CH_PLUS:  op = OP_ADD;
      CH_MINUS: op = OP_SUB;
      CH_STAR:  op = OP_MUL;
      CH_SLASH: op = OP_DIV;
      default: begin bad_char = 1; return; end
    endcase
    if (broken || defer_err) return;
    if (phase == PH_EXPECT) begin
      if (op == OP_SUB) begin phase = PH_SIGN; lit_neg = 1; end
      else if (op != OP_ADD) defer_err = 1;
    end else if (phase == PH_SIGN) begin
      defer_err = 1;
    end else begin
      close_literal(held_val, held_ovf);
      held_op = op; phase = PH_EXPECT;
      lit_neg = 0; lit_mag = '0; lit_ovf = 0;
    end
  endfunction

  function automatic void eval_end();
    eval_result_t r;
    logic [63:0] v;
    logic o;
    r.value = '0;
    r.code = ERR_NONE;
    if (bad_char) r.code = ERR_INVALID;
    else if (broken || !had_digit) r.code = ERR_MALFORMED;
    else begin
      if (phase == PH_DIGITS) close_literal(v, o);
      else begin v = held_val; o = held_ovf; end
      fold_operand(v, o, OP_ADD);
      if (chain_err != ERR_NONE) r.code = chain_err;
      else if (add_ovf) r.code = ERR_OVERFLOW;
      else r.value = sum_acc;
    end
    pending_results = {pending_results, r};
    clear_eval();
  endfunction

  task automatic send_item(logic cmd, logic [7:0] ch);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_character <= ch;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_END) eval_end();
    else eval_char(ch);
  endtask

  task automatic send_expr(string s);
    for (int i = 0; i < s.len(); i++) send_item(CMD_CHAR, s[i]);
    send_item(CMD_END, 8'($urandom_range(255)));
  endtask

  // result checker
  always @(posedge clk) begin
    eval_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: value %0d code %0d",
                   $signed(out_result_value), out_error_code);
      end else begin
        want = pending_results.pop_front();
        if (out_result_value !== want.value || out_error_code !== want.code) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %0d code %0d, got value %0d code %0d",
                     $signed(want.value), want.code, $signed(out_result_value),
                     out_error_code);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic test_directed();
    send_expr("1+2*3-8/3");
    send_expr("-9223372036854775808");
    send_expr("9223372036854775807+1");
    send_expr("9223372036854775808");
    send_expr("-9223372036854775808/-1");
    send_expr("5/0");
    send_expr(" 7 / -2 ");
    send_expr("1a");
    send_item(CMD_CHAR, 8'hff);
    send_expr("3");
    send_expr("");
    send_expr("*3");
    send_expr("--3");
    send_expr("3*+");
    send_expr("+4*-0");
  endtask

  function automatic string rand_literal();
    string s;
    int n, k;
    s = "";
    k = $urandom_range(99);
    n = (k < 70) ? $urandom_range(1, 3) : (k < 90) ? $urandom_range(4, 19) : 20;
    for (int i = 0; i < n; i++) begin
      if (i == 0 && n >= 19) s = {s, "9"};
      else s = {s, $sformatf("%c", 8'(CH_ZERO + $urandom_range(9)))};
    end
    return s;
  endfunction

  function automatic string rand_op();
    case ($urandom_range(3))
      0: return "+";
      1: return "-";
      2: return "*";
      default: return "/";
    endcase
  endfunction

  task automatic test_random(int exprs);
    string s;
    int terms;
    for (int e = 0; e < exprs; e++) begin
      s = "";
      terms = $urandom_range(1, 5);
      for (int t = 0; t < terms; t++) begin
        if ($urandom_range(9) == 0) s = {s, " "};
        if ($urandom_range(4) == 0) s = {s, ($urandom_range(1) ? "-" : "+")};
        // broken sequences now and then
        if ($urandom_range(19) == 0) s = {s, rand_op()};
        if ($urandom_range(39) == 0) s = {s, $sformatf("%c", 8'($urandom_range(255)))};
        s = {s, rand_literal()};
        if (t != terms - 1 || $urandom_range(9) == 0) s = {s, rand_op()};
      end
      send_expr(s);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    clear_eval();
    @(posedge clk);
    test_directed();
    send_idle = 38; recv_idle = 48;
    test_random(8);
    send_idle = 48; recv_idle = 38;
    test_random(8);
    send_idle = 0; recv_idle = 0;
    test_random(8);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("infix_expression_evaluator_unit_test: clean");
    else
      $display("infix_expression_evaluator_unit_test: errors");
    $finish;
  end

  initial begin
    #40ms;
    $display("infix_expression_evaluator_unit_test: errors");
    $finish;
  end

endmodule
